@@ rtl/cht_pkg.sv @@
`timescale 1ns / 1ps
package cht_pkg;
  localparam int MAX_LINES_DEF = 1024;
  localparam int SLOPE_W = 32;
  localparam int VALUE_W = 64;
  localparam int LINE_W = SLOPE_W + VALUE_W;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
endpackage

@@ rtl/cht_ram.sv @@
`timescale 1ns / 1ps
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

@@ rtl/convex_hull_trick_dp.sv @@
`timescale 1ns / 1ps
// Convex hull trick engine for a running minimum DP.
// Request channel: in_restart, in_new_slope, in_query_x are taken at a rising
// edge with start high and busy low. The block adds the line
// y = in_new_slope * x + c (c = previous result, or 0 on restart), pops
// dominated lines, binary-searches the hull at in_query_x and returns the
// minimum on out_dp_value / out_saturated with out_valid high for one cycle.
// Steps: when two or more lines are held, the first dominance test takes two
// hull memory reads, four 33x33 partial products on one shared multiplier and
// one compare, and each popped line repeats it with one more read; then come
// the push, at most ceil(log2(lines)) search steps (each two memory reads of
// the single read port), the final evaluation, and the registered result.
// busy stays high from the accepted request until the result cycle, so one
// request is in flight at a time and the next is taken at the end of the
// result cycle; pops average at most one per request.
// Reset clears the line count and the stored intercept; the hull memory is
// not cleared, as only written entries are ever read.
// The receiver cannot stall: each result is shown for exactly one cycle.
module convex_hull_trick_dp
  import cht_pkg::*;
#(
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_restart,
  input  logic signed [SLOPE_W-1:0] in_new_slope,
  input  logic signed [SLOPE_W-1:0] in_query_x,
  output logic                      out_valid,
  output logic signed [VALUE_W-1:0] out_dp_value,
  output logic                      out_saturated
);
  localparam int AW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);
  localparam int SW = CW + 1;
  localparam int DW = VALUE_W + 1;
  localparam int EW = SLOPE_W + 1;
  localparam int PW = 2 * EW;
  localparam int ACW = DW + EW + 2;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LD_T = 4'd1;
  localparam logic [3:0] ST_LD_S = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_CMP  = 4'd4;
  localparam logic [3:0] ST_PUSH = 4'd5;
  localparam logic [3:0] ST_SR_A = 4'd6;
  localparam logic [3:0] ST_SR_B = 4'd7;
  localparam logic [3:0] ST_SR_C = 4'd8;
  localparam logic [3:0] ST_SR_D = 4'd9;
  localparam logic [3:0] ST_FN_B = 4'd10;
  localparam logic [3:0] ST_FN_C = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic signed [VALUE_W-1:0] last_r, last_nxt;
  logic signed [SLOPE_W-1:0] na_r, na_nxt, x_r, x_nxt;
  logic signed [VALUE_W-1:0] nb_r, nb_nxt;
  logic signed [SLOPE_W-1:0] ta_r, ta_nxt, sa_r, sa_nxt;
  logic signed [VALUE_W-1:0] tb_r, tb_nxt, sb_r, sb_nxt;
  logic signed [DW-1:0] d1_r, d1_nxt, d2_r, d2_nxt;
  logic signed [EW-1:0] e1_r, e1_nxt, e2_r, e2_nxt;
  logic [2:0] step_r, step_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [ACW-1:0] accl_r, accl_nxt, accr_r, accr_nxt;
  logic signed [SW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, best_r, best_nxt, m_r, m_nxt;
  logic signed [VALUE_W-1:0] p_r, p_nxt, b_r, b_nxt;
  logic signed [DW-1:0] v0_r, v0_nxt;
  logic out_valid_r, out_valid_nxt, out_sat_r, out_sat_nxt;
  logic signed [VALUE_W-1:0] out_dp_r, out_dp_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [LINE_W-1:0] wdata, rdata;
  logic signed [SLOPE_W-1:0] rd_slope;
  logic signed [VALUE_W-1:0] rd_icpt;
  logic [CW-1:0] cnt0, cnt_push;
  logic signed [DW-1:0] mul_d, vsum;
  logic signed [EW-1:0] mul_a, mul_e;
  logic [2:0] tag;
  logic signed [ACW-1:0] term;
  logic signed [SW-1:0] m_c;

  cht_ram #(.WIDTH(LINE_W), .DEPTH(MAX_LINES)) u_hull (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_slope = rdata[LINE_W-1:VALUE_W];
  assign rd_icpt  = rdata[VALUE_W-1:0];
  assign vsum = {p_r[VALUE_W-1], p_r} + {b_r[VALUE_W-1], b_r};
  assign mul_d = step_r[1] ? d2_r : d1_r;
  assign mul_e = step_r[1] ? e2_r : e1_r;
  assign mul_a = step_r[0] ? mul_d[DW-1:SLOPE_W] : {1'b0, mul_d[SLOPE_W-1:0]};
  assign tag = step_r - 3'd1;
  assign term = tag[0] ? (ACW'(prod_r) <<< SLOPE_W) : ACW'(prod_r);
  assign m_c = lo_r + ((hi_r - lo_r) >>> 1);
  assign cnt0 = in_restart ? '0 : count_r;
  assign cnt_push = (count_r >= CW'(MAX_LINES)) ? CW'(MAX_LINES - 1) : count_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    last_nxt = last_r;
    na_nxt = na_r;
    x_nxt = x_r;
    nb_nxt = nb_r;
    ta_nxt = ta_r;
    tb_nxt = tb_r;
    sa_nxt = sa_r;
    sb_nxt = sb_r;
    d1_nxt = d1_r;
    d2_nxt = d2_r;
    e1_nxt = e1_r;
    e2_nxt = e2_r;
    step_nxt = step_r;
    prod_nxt = prod_r;
    accl_nxt = accl_r;
    accr_nxt = accr_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    best_nxt = best_r;
    m_nxt = m_r;
    p_nxt = p_r;
    b_nxt = b_r;
    v0_nxt = v0_r;
    out_valid_nxt = 1'b0;
    out_sat_nxt = out_sat_r;
    out_dp_nxt = out_dp_r;
    we = 1'b0;
    waddr = cnt_push[AW-1:0];
    wdata = {na_r, nb_r};
    raddr = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          na_nxt = in_new_slope;
          x_nxt = in_query_x;
          nb_nxt = in_restart ? '0 : last_r;
          count_nxt = cnt0;
          raddr = AW'(cnt0 - CW'(1));
          state_nxt = (cnt0 >= CW'(2)) ? ST_LD_T : ST_PUSH;
        end
      end
      ST_LD_T: begin
        ta_nxt = rd_slope;
        tb_nxt = rd_icpt;
        raddr = AW'(count_r - CW'(2));
        state_nxt = ST_LD_S;
      end
      ST_LD_S: begin
        sa_nxt = rd_slope;
        sb_nxt = rd_icpt;
        d1_nxt = {nb_r[VALUE_W-1], nb_r} - {rd_icpt[VALUE_W-1], rd_icpt};
        e1_nxt = {rd_slope[SLOPE_W-1], rd_slope} - {ta_r[SLOPE_W-1], ta_r};
        d2_nxt = {tb_r[VALUE_W-1], tb_r} - {rd_icpt[VALUE_W-1], rd_icpt};
        e2_nxt = {rd_slope[SLOPE_W-1], rd_slope} - {na_r[SLOPE_W-1], na_r};
        step_nxt = '0;
        accl_nxt = '0;
        accr_nxt = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (step_r != 3'd4) begin
          prod_nxt = mul_a * mul_e;
        end
        if (step_r != 3'd0) begin
          if (tag[1]) begin
            accr_nxt = accr_r + term;
          end else begin
            accl_nxt = accl_r + term;
          end
        end
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd4) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (accl_r <= accr_r) begin
          count_nxt = count_r - CW'(1);
          ta_nxt = sa_r;
          tb_nxt = sb_r;
          raddr = AW'(count_r - CW'(3));
          state_nxt = (count_r >= CW'(3)) ? ST_LD_S : ST_PUSH;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        we = 1'b1;
        count_nxt = cnt_push + CW'(1);
        lo_nxt = '0;
        hi_nxt = SW'(cnt_push) - SW'(1);
        best_nxt = SW'(cnt_push);
        state_nxt = ST_SR_A;
      end
      ST_SR_A: begin
        if (lo_r <= hi_r) begin
          m_nxt = m_c;
          raddr = m_c[AW-1:0];
          state_nxt = ST_SR_B;
        end else begin
          raddr = best_r[AW-1:0];
          state_nxt = ST_FN_B;
        end
      end
      ST_SR_B: begin
        raddr = AW'(m_r + SW'(1));
        p_nxt = rd_slope * x_r;
        b_nxt = rd_icpt;
        state_nxt = ST_SR_C;
      end
      ST_SR_C: begin
        v0_nxt = vsum;
        p_nxt = rd_slope * x_r;
        b_nxt = rd_icpt;
        state_nxt = ST_SR_D;
      end
      ST_SR_D: begin
        if (v0_r <= vsum) begin
          best_nxt = m_r;
          hi_nxt = m_r - SW'(1);
        end else begin
          lo_nxt = m_r + SW'(1);
        end
        state_nxt = ST_SR_A;
      end
      ST_FN_B: begin
        p_nxt = rd_slope * x_r;
        b_nxt = rd_icpt;
        state_nxt = ST_FN_C;
      end
      ST_FN_C: begin
        if (vsum[DW-1] == vsum[DW-2]) begin
          out_dp_nxt = vsum[VALUE_W-1:0];
          out_sat_nxt = 1'b0;
        end else begin
          out_dp_nxt = vsum[DW-1] ? VALUE_MIN : VALUE_MAX;
          out_sat_nxt = 1'b1;
        end
        last_nxt = out_dp_nxt;
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      last_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      last_r <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    na_r <= na_nxt;
    x_r <= x_nxt;
    nb_r <= nb_nxt;
    ta_r <= ta_nxt;
    tb_r <= tb_nxt;
    sa_r <= sa_nxt;
    sb_r <= sb_nxt;
    d1_r <= d1_nxt;
    d2_r <= d2_nxt;
    e1_r <= e1_nxt;
    e2_r <= e2_nxt;
    step_r <= step_nxt;
    prod_r <= prod_nxt;
    accl_r <= accl_nxt;
    accr_r <= accr_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    best_r <= best_nxt;
    m_r <= m_nxt;
    p_r <= p_nxt;
    b_r <= b_nxt;
    v0_r <= v0_nxt;
    out_sat_r <= out_sat_nxt;
    out_dp_r <= out_dp_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_dp_value = out_dp_r;
  assign out_saturated = out_sat_r;
endmodule

@@ rtl/cht_chk.sv @@
`timescale 1ns / 1ps
module cht_chk
  import cht_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic signed [VALUE_W-1:0] out_dp_value,
  input logic                      out_saturated
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request taken without going busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without a request in work");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("two results back to back");

  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_dp_value == VALUE_MAX || out_dp_value == VALUE_MIN)
    else $error("saturated result not at a range limit");
endmodule

bind convex_hull_trick_dp cht_chk u_cht_chk (.*);
